// File: rtl/core/round_robin_slot_scheduler_assert.svh
// assertion helpers for the slot scheduler, sampled on clk and held off during rst
`ifndef ROUND_ROBIN_SLOT_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_SLOT_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define RRSS_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRSS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rrss_pkg.sv
package rrss_pkg;

  typedef logic [1:0] slot_state_t;

  localparam slot_state_t ST_FREE    = 2'd0;
  localparam slot_state_t ST_READY   = 2'd1;
  localparam slot_state_t ST_RUNNING = 2'd2;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] STAT_SCHEDULED  = 2'd0;
  localparam logic [1:0] STAT_NOTHING    = 2'd1;
  localparam logic [1:0] STAT_WRITE_DONE = 2'd2;
  localparam logic [1:0] STAT_QUERY      = 2'd3;

  localparam logic [1:0] FORK_NONE    = 2'd0;
  localparam logic [1:0] FORK_CREATED = 2'd1;
  localparam logic [1:0] FORK_NO_FREE = 2'd2;

  // summary flags gathered by one pass over the slot table
  typedef struct packed {
    logic any_busy;
    logic ready_found;
    logic free_found;
    logic after_found;
  } scan_flags_t;

endpackage

// File: rtl/core/rrss_scan.sv
module rrss_scan import rrss_pkg::*; #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clear,
  input  logic                            sample,
  input  logic [$clog2(SLOT_COUNT)-1:0]   idx,
  input  slot_state_t                     st,
  input  logic [$clog2(SLOT_COUNT)-1:0]   cur,
  output scan_flags_t                     flags,
  output logic [$clog2(SLOT_COUNT)-1:0]   lowest_ready,
  output logic [$clog2(SLOT_COUNT)-1:0]   lowest_free,
  output logic [$clog2(SLOT_COUNT)-1:0]   after_slot,
  output logic [$clog2(SLOT_COUNT)-1:0]   first_slot
);

  logic first_found;
  logic eligible;

  // a slot can be picked when ready or already running
  assign eligible = (st == ST_READY) || (st == ST_RUNNING);

  // slots arrive in ascending order, so the first hit is the lowest
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags       <= '0;
      first_found <= 1'b0;
    end else if (sample) begin
      if (st != ST_FREE) begin
        flags.any_busy <= 1'b1;
      end
      if (st == ST_READY && !flags.ready_found) begin
        flags.ready_found <= 1'b1;
        lowest_ready      <= idx;
      end
      if (st == ST_FREE && !flags.free_found) begin
        flags.free_found <= 1'b1;
        lowest_free      <= idx;
      end
      if (eligible && !first_found) begin
        first_found <= 1'b1;
        first_slot  <= idx;
      end
      if (eligible && idx > cur && !flags.after_found) begin
        flags.after_found <= 1'b1;
        after_slot        <= idx;
      end
    end
  end

endmodule

// File: rtl/core/round_robin_slot_scheduler.sv
// round-robin slot scheduler: slot table in one single-port-read, one-write memory
// tick: done strobes once one full pass over the table, at one memory read a cycle, and
//   the read-modify-writes after it are through; with nothing to run no write is made
// set and query: done after the entry is read, and for a set written back; out-of-range
//   or ignored requests are answered from idle. one request at a time; busy stays high
//   until the result strobe, which cannot be stalled; after rst the table is zeroed, busy high
`include "round_robin_slot_scheduler_assert.svh"

module round_robin_slot_scheduler import rrss_pkg::*; #(
  parameter int SLOT_COUNT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic       fork_request,
  input  logic [5:0] slot_index,
  input  logic [1:0] new_state,
  output logic       done,
  output logic [1:0] status,
  output logic       running_valid,
  output logic [5:0] running_slot,
  output logic [1:0] fork_result,
  output logic [5:0] child_slot,
  output logic [1:0] queried_state,
  output logic [5:0] queried_parent,
  output logic [5:0] queried_child
);

  localparam int SW = $clog2(SLOT_COUNT);
  // memory word: state, parent, latest child
  localparam int WW = 2 + 2 * SW;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

  // sequencer codes
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_DRAIN    = 4'd3;
  localparam logic [3:0] S_DECIDE   = 4'd4;
  localparam logic [3:0] S_OLD_WR   = 4'd5;
  localparam logic [3:0] S_RUN_RD   = 4'd6;
  localparam logic [3:0] S_RUN_WR   = 4'd7;
  localparam logic [3:0] S_CHILD_WR = 4'd8;
  localparam logic [3:0] S_SET_WR   = 4'd9;
  localparam logic [3:0] S_QUERY_RD = 4'd10;

  logic [3:0]    state, state_next;
  logic [SW-1:0] cnt, cnt_next;
  logic          samp_valid, samp_valid_next;
  logic [SW-1:0] samp_idx, samp_idx_next;
  logic          cur_valid, cur_valid_next;
  logic [SW-1:0] cur_slot, cur_slot_next;
  logic [SW-1:0] pick, pick_next;
  logic          fork_req, fork_req_next;
  logic [SW-1:0] req_slot, req_slot_next;
  slot_state_t   req_state, req_state_next;

  logic       done_next;
  logic [1:0] status_next;
  logic       running_valid_next;
  logic [5:0] running_slot_next;
  logic [1:0] fork_result_next;
  logic [5:0] child_slot_next;
  logic [1:0] queried_state_next;
  logic [5:0] queried_parent_next;
  logic [5:0] queried_child_next;

  // slot table
  logic [WW-1:0] mem [SLOT_COUNT];
  logic [SW-1:0] rd_addr;
  logic [WW-1:0] rd_data;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [WW-1:0] wr_data;

  slot_state_t   rd_state;
  logic [SW-1:0] rd_parent;
  logic [SW-1:0] rd_child;

  scan_flags_t   flags;
  logic [SW-1:0] lowest_ready;
  logic [SW-1:0] lowest_free;
  logic [SW-1:0] after_slot;
  logic [SW-1:0] first_slot;

  logic in_range;

  assign rd_state  = rd_data[WW-1 -: 2];
  assign rd_parent = rd_data[2*SW-1 -: SW];
  assign rd_child  = rd_data[SW-1:0];

  assign in_range = 32'(slot_index) < SLOT_COUNT;
  assign busy     = (state != S_IDLE);

  // read-before-write: a read of an entry in the cycle it is written returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // running summary of the table while a tick sweeps it
  rrss_scan #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .clear        (state == S_IDLE),
    .sample       (samp_valid),
    .idx          (samp_idx),
    .st           (rd_state),
    .cur          (cur_slot),
    .flags        (flags),
    .lowest_ready (lowest_ready),
    .lowest_free  (lowest_free),
    .after_slot   (after_slot),
    .first_slot   (first_slot)
  );

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    samp_valid_next = 1'b0;
    samp_idx_next   = cnt;
    cur_valid_next  = cur_valid;
    cur_slot_next   = cur_slot;
    pick_next       = pick;
    fork_req_next   = fork_req;
    req_slot_next   = req_slot;
    req_state_next  = req_state;

    rd_addr = req_slot;
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = '0;

    // result fields read as zero (status as write-done) unless this cycle completes a request
    done_next           = 1'b0;
    status_next         = STAT_WRITE_DONE;
    running_valid_next  = 1'b0;
    running_slot_next   = '0;
    fork_result_next    = FORK_NONE;
    child_slot_next     = '0;
    queried_state_next  = ST_FREE;
    queried_parent_next = '0;
    queried_child_next  = '0;

    case (state)
      // sweep zeros through the table after reset
      S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = cnt;
        wr_data  = '0;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_SLOT) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        rd_addr = SW'(slot_index);
        if (start) begin
          fork_req_next  = fork_request;
          req_slot_next  = SW'(slot_index);
          req_state_next = new_state;
          case (req_type)
            REQ_TICK: begin
              cnt_next   = '0;
              state_next = S_SCAN;
            end
            REQ_SET: begin
              if (in_range && new_state <= ST_RUNNING) begin
                state_next = S_SET_WR;
              end else begin
                done_next   = 1'b1;
                status_next = STAT_WRITE_DONE;
              end
            end
            REQ_QUERY: begin
              if (in_range) begin
                state_next = S_QUERY_RD;
              end else begin
                done_next   = 1'b1;
                status_next = STAT_QUERY;
              end
            end
            default: begin
              done_next   = 1'b1;
              status_next = STAT_WRITE_DONE;
            end
          endcase
        end
      end

      // one read a cycle; the registered data and index reach the scan unit in the next cycle
      S_SCAN: begin
        rd_addr         = cnt;
        samp_valid_next = 1'b1;
        samp_idx_next   = cnt;
        cnt_next        = cnt + 1'b1;
        if (cnt == LAST_SLOT) begin
          state_next = S_DRAIN;
        end
      end

      // last slot is being folded into the summary
      S_DRAIN: begin
        state_next = S_DECIDE;
      end

      S_DECIDE: begin
        rd_addr = cur_slot;
        if (!flags.any_busy) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          status_next = STAT_NOTHING;
        end else if (!cur_valid) begin
          if (flags.ready_found) begin
            pick_next  = lowest_ready;
            state_next = S_RUN_RD;
          end else begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            status_next = STAT_NOTHING;
          end
        end else begin
          // the current slot is itself eligible, so a wrap always finds one
          if (flags.after_found) begin
            pick_next = after_slot;
          end else begin
            pick_next = first_slot;
          end
          if (pick_next != cur_slot) begin
            state_next = S_OLD_WR;
          end else begin
            state_next = S_RUN_RD;
          end
        end
      end

      // outgoing slot drops back to ready
      S_OLD_WR: begin
        wr_en      = 1'b1;
        wr_addr    = cur_slot;
        wr_data    = {ST_READY, rd_parent, rd_child};
        state_next = S_RUN_RD;
      end

      S_RUN_RD: begin
        rd_addr    = pick;
        state_next = S_RUN_WR;
      end

      S_RUN_WR: begin
        wr_en          = 1'b1;
        wr_addr        = pick;
        wr_data        = {ST_RUNNING, rd_parent,
                          (fork_req && flags.free_found) ? lowest_free : rd_child};
        cur_valid_next = 1'b1;
        cur_slot_next  = pick;
        if (fork_req && flags.free_found) begin
          state_next = S_CHILD_WR;
        end else begin
          state_next       = S_IDLE;
          done_next        = 1'b1;
          status_next      = STAT_SCHEDULED;
          fork_result_next = fork_req ? FORK_NO_FREE : FORK_NONE;
        end
      end

      // new child: ready, linked back to its parent, no child of its own
      S_CHILD_WR: begin
        wr_en            = 1'b1;
        wr_addr          = lowest_free;
        wr_data          = {ST_READY, pick, {SW{1'b0}}};
        state_next       = S_IDLE;
        done_next        = 1'b1;
        status_next      = STAT_SCHEDULED;
        fork_result_next = FORK_CREATED;
        child_slot_next  = 6'(lowest_free);
      end

      S_SET_WR: begin
        wr_en   = 1'b1;
        wr_addr = req_slot;
        wr_data = {req_state, rd_parent, rd_child};
        // freeing the running slot drops the selection
        if (req_state == ST_FREE && cur_valid && cur_slot == req_slot) begin
          cur_valid_next = 1'b0;
        end
        state_next  = S_IDLE;
        done_next   = 1'b1;
        status_next = STAT_WRITE_DONE;
      end

      S_QUERY_RD: begin
        state_next          = S_IDLE;
        done_next           = 1'b1;
        status_next         = STAT_QUERY;
        queried_state_next  = rd_state;
        queried_parent_next = 6'(rd_parent);
        queried_child_next  = 6'(rd_child);
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // every result reports the selection as it stands after the request
    if (done_next) begin
      running_valid_next = cur_valid_next;
      running_slot_next  = cur_valid_next ? 6'(cur_slot_next) : 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      samp_valid <= 1'b0;
      cur_valid  <= 1'b0;
      cur_slot   <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      samp_valid <= samp_valid_next;
      cur_valid  <= cur_valid_next;
      cur_slot   <= cur_slot_next;
      done       <= done_next;
    end
  end

  // request payload and result fields
  always_ff @(posedge clk) begin
    samp_idx       <= samp_idx_next;
    pick           <= pick_next;
    fork_req       <= fork_req_next;
    req_slot       <= req_slot_next;
    req_state      <= req_state_next;
    status         <= status_next;
    running_valid  <= running_valid_next;
    running_slot   <= running_slot_next;
    fork_result    <= fork_result_next;
    child_slot     <= child_slot_next;
    queried_state  <= queried_state_next;
    queried_parent <= queried_parent_next;
    queried_child  <= queried_child_next;
  end

  // a result always lands with the sequencer back at rest
  `RRSS_IMPLIES(a_done_idle, done, !busy, "result strobe while sequencer busy")
  // no selection means a zero slot number
  `RRSS_IMPLIES(a_idle_slot_zero, done && !running_valid, running_slot == 6'd0,
    "running slot non-zero without a selection")
  // an accepted request either starts work or answers at once
  `RRSS_NEXT(a_start_moves, start && !busy, busy || done, "accepted request dropped")
  // a child is only created on a successful schedule
  `RRSS_IMPLIES(a_fork_sched, done && fork_result == FORK_CREATED,
    status == STAT_SCHEDULED && running_valid, "child created without a schedule")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rrss_pkg::*;

  localparam int SLOTS          = 64;
  localparam int RANDOM_ITEMS   = 400;
  // the last stretch of requests goes back to back
  localparam int CALM_TAIL      = 60;
  // covers the longest tick, plus margin
  localparam int DRAIN_CYCLES   = SLOTS + 16;
  // covers the clearing sweep after reset, a full tick and an idle burst many times over
  localparam int WATCHDOG_LIMIT = 2000;
  // printed mismatch lines are capped, all of them are counted
  localparam int MAX_REPORTS    = 30;

  // codes with no name in the package
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam slot_state_t ST_INVALID  = 2'd3;

  // one request as it goes to the block
  typedef struct packed {
    logic [1:0] kind;
    logic       fork_req;
    logic [5:0] slot;
    logic [1:0] state;
  } sched_req_t;

  // one result as it leaves the block, fields in port order
  typedef struct packed {
    logic [1:0] status;
    logic       run_valid;
    logic [5:0] run_slot;
    logic [1:0] fork_res;
    logic [5:0] child;
    logic [1:0] q_state;
    logic [5:0] q_parent;
    logic [5:0] q_child;
  } sched_resp_t;

  // shadow copy of the slot table and the queue of results it predicts
  class slot_scoreboard;
    slot_state_t slot_state [SLOTS];
    logic [5:0]  parent_of [SLOTS];
    logic [5:0]  child_of [SLOTS];
    logic        cur_valid;
    logic [5:0]  cur_slot;
    sched_resp_t pending [$];
    int n_req, n_ignored, n_checked, n_errors;
    int n_sched, n_nothing, n_sets, n_queries, n_forked, n_fork_full;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i] = ST_FREE;
        parent_of[i]  = '0;
        child_of[i]   = '0;
      end
      cur_valid = 1'b0;
      cur_slot  = '0;
    endfunction

    function bit lowest_in(slot_state_t want, output logic [5:0] at);
      bit hit;
      hit = 1'b0;
      at  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (slot_state[i] == want) begin
          at  = 6'(i);
          hit = 1'b1;
        end
      end
      return hit;
    endfunction

    // called at the edge where a request is taken
    function void note_request(sched_req_t r);
      sched_resp_t want;
      bit          any_busy;
      logic [5:0]  s;
      logic [5:0]  c;
      want        = '0;
      want.status = STAT_WRITE_DONE;
      n_req++;
      case (r.kind)
        REQ_TICK: begin
          any_busy = 1'b0;
          foreach (slot_state[i]) if (slot_state[i] != ST_FREE) any_busy = 1'b1;
          if (!any_busy) begin
            want.status = STAT_NOTHING;
            n_nothing++;
          end else if (!cur_valid && !lowest_in(ST_READY, s)) begin
            want.status = STAT_NOTHING;
            n_nothing++;
          end else begin
            if (!cur_valid) begin
              cur_valid = 1'b1;
              cur_slot  = s;
            end else begin
              // current goes back to ready, then the scan wraps round to it at worst
              slot_state[cur_slot] = ST_READY;
              s = cur_slot;
              do s++; while (slot_state[s] != ST_READY && slot_state[s] != ST_RUNNING);
              cur_slot = s;
            end
            want.status          = STAT_SCHEDULED;
            slot_state[cur_slot] = ST_RUNNING;
            n_sched++;
            if (r.fork_req) begin
              if (lowest_in(ST_FREE, c)) begin
                child_of[cur_slot] = c;
                slot_state[c]      = ST_READY;
                child_of[c]        = '0;
                parent_of[c]       = cur_slot;
                want.fork_res      = FORK_CREATED;
                want.child         = c;
                n_forked++;
              end else begin
                want.fork_res = FORK_NO_FREE;
                n_fork_full++;
              end
            end
          end
        end
        REQ_SET: begin
          n_sets++;
          if (r.state == ST_INVALID) begin
            n_ignored++;
          end else begin
            slot_state[r.slot] = r.state;
            if (r.state == ST_FREE && cur_valid && cur_slot == r.slot) cur_valid = 1'b0;
          end
        end
        REQ_QUERY: begin
          n_queries++;
          want.status   = STAT_QUERY;
          want.q_state  = slot_state[r.slot];
          want.q_parent = parent_of[r.slot];
          want.q_child  = child_of[r.slot];
        end
        default: n_ignored++;
      endcase
      want.run_valid = cur_valid;
      want.run_slot  = cur_valid ? cur_slot : 6'd0;
      pending.push_back(want);
    endfunction

    task report(string msg);
      if (n_errors < MAX_REPORTS) $display("mismatch: %s", msg);
      n_errors++;
    endtask

    task cmp(string field, logic [5:0] got_v, logic [5:0] want_v);
      if (got_v !== want_v)
        report($sformatf("result %0d %s is %0d, expected %0d", n_checked, field, got_v, want_v));
    endtask

    task check_result(sched_resp_t got);
      sched_resp_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %h with no request outstanding", got));
        return;
      end
      want = pending.pop_front();
      n_checked++;
      cmp("status", got.status, want.status);
      cmp("running_valid", got.run_valid, want.run_valid);
      cmp("running_slot", got.run_slot, want.run_slot);
      cmp("fork_result", got.fork_res, want.fork_res);
      cmp("child_slot", got.child, want.child);
      cmp("queried_state", got.q_state, want.q_state);
      cmp("queried_parent", got.q_parent, want.q_parent);
      cmp("queried_child", got.q_child, want.q_child);
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] req_type = REQ_TICK;
  logic       fork_request = 1'b0;
  logic [5:0] slot_index = '0;
  logic [1:0] new_state = ST_FREE;
  logic       busy;
  logic       done;
  logic [1:0] status;
  logic       running_valid;
  logic [5:0] running_slot;
  logic [1:0] fork_result;
  logic [5:0] child_slot;
  logic [1:0] queried_state;
  logic [5:0] queried_parent;
  logic [5:0] queried_child;

  slot_scoreboard sb;
  bit idling_on = 1'b1;
  int quiet_cycles = 0;

  round_robin_slot_scheduler #(.SLOT_COUNT(SLOTS)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .fork_request   (fork_request),
    .slot_index     (slot_index),
    .new_state      (new_state),
    .done           (done),
    .status         (status),
    .running_valid  (running_valid),
    .running_slot   (running_slot),
    .fork_result    (fork_result),
    .child_slot     (child_slot),
    .queried_state  (queried_state),
    .queried_parent (queried_parent),
    .queried_child  (queried_child)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // results are taken on the edge that closes their strobe cycle, pre-edge values
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result('{status, running_valid, running_slot, fork_result, child_slot,
                        queried_state, queried_parent, queried_child});
  end

  // watchdog: any accepted request or result counts as progress
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start stays high after a take, so back-to-back requests never drop it within a step
  task automatic send(logic [1:0] kind, logic fork_req, logic [5:0] slot, logic [1:0] state);
    sched_req_t r;
    r            = '{kind, fork_req, slot, state};
    start        <= 1'b1;
    req_type     <= kind;
    fork_request <= fork_req;
    slot_index   <= slot;
    new_state    <= state;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    // random pause on the sending side, in bursts
    if (idling_on && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk);
    end
  endtask

  // a tick with don't-care slot and state fields scrambled
  task automatic tick(logic fork_req);
    send(REQ_TICK, fork_req, 6'($urandom_range(63)), 2'($urandom_range(3)));
  endtask

  // occupy every free slot, then fork so the table is found full
  task automatic fill_table();
    for (int i = 0; i < SLOTS; i++) begin
      if (sb.slot_state[i] == ST_FREE)
        send(REQ_SET, 1'($urandom_range(1)), 6'(i), $urandom_range(1) ? ST_READY : ST_RUNNING);
    end
    tick(1'b1);
    send(REQ_QUERY, 1'($urandom_range(1)), sb.cur_slot, 2'($urandom_range(3)));
    tick(1'b1);
  endtask

  // slot picked for a write or a query: the current one is favoured now and then
  function automatic logic [5:0] pick_slot();
    if (sb.cur_valid && $urandom_range(4) == 0) return sb.cur_slot;
    return 6'($urandom_range(63));
  endfunction

  task automatic random_request();
    int dice;
    dice = $urandom_range(99);
    if (dice < 40)
      tick(1'($urandom_range(1)));
    else if (dice < 70)
      send(REQ_SET, 1'($urandom_range(1)), pick_slot(),
           $urandom_range(19) == 0 ? ST_INVALID : slot_state_t'($urandom_range(2)));
    else if (dice < 95)
      send(REQ_QUERY, 1'($urandom_range(1)), pick_slot(), 2'($urandom_range(3)));
    else
      send(REQ_UNUSED, 1'($urandom_range(1)), 6'($urandom_range(63)), 2'($urandom_range(3)));
  endtask

  initial begin
    int base;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, no ready slot, first pick, wrap, forks, ignored codes
    tick(1'b1);                                   // every slot free
    send(REQ_QUERY, 1'b1, 6'd63, ST_INVALID);
    send(REQ_SET, 1'b0, 6'd63, ST_RUNNING);
    tick(1'b1);                                   // busy slots but none ready and no current
    send(REQ_SET, 1'b1, 6'd0, ST_READY);
    tick(1'b1);                                   // lowest ready picked, child in slot 1
    tick(1'b0);
    tick(1'b1);                                   // round robin reaches the running slot
    send(REQ_QUERY, 1'b0, 6'd1, ST_FREE);
    send(REQ_QUERY, 1'b0, 6'd0, ST_FREE);
    send(REQ_QUERY, 1'b1, 6'd63, ST_READY);
    send(REQ_SET, 1'b1, 6'd7, ST_INVALID);        // state code three is dropped
    send(REQ_UNUSED, 1'b1, 6'd63, ST_INVALID);    // unused request type
    send(REQ_SET, 1'b0, 6'd63, ST_FREE);          // freeing the current slot clears it
    tick(1'b0);
    send(REQ_SET, 1'b0, sb.cur_slot, ST_READY);
    tick(1'b0);
    send(REQ_SET, 1'b0, 6'd42, ST_RUNNING);
    send(REQ_QUERY, 1'b0, 6'd42, ST_RUNNING);
    fill_table();                                 // fork with no free slot left

    // random phases until enough meaningful requests have gone through
    base = sb.n_req - sb.n_ignored;
    while (sb.n_req - sb.n_ignored < base + RANDOM_ITEMS) begin
      if (sb.n_req - sb.n_ignored >= base + RANDOM_ITEMS - CALM_TAIL) idling_on = 1'b0;
      case ($urandom_range(9))
        0: fill_table();
        1, 2: repeat ($urandom_range(20, 4)) send(REQ_SET, 1'($urandom_range(1)), pick_slot(),
                                                  ST_FREE);
        3, 4: repeat ($urandom_range(10, 3)) tick(1'($urandom_range(3) != 0));
        default: repeat (10) random_request();
      endcase
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d ticks scheduled, %0d with nothing to run, %0d writes, %0d queries",
             sb.n_req, sb.n_sched, sb.n_nothing, sb.n_sets, sb.n_queries);
    $display("forks: %0d children made, %0d refused on a full table; %0d results checked, %0d mismatches",
             sb.n_forked, sb.n_fork_full, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
